### hw/rtl/i2cm_pkg.sv
// I2C master byte engine: shared types and constants.
// Operation codes, phase numbers and the request/response beat layouts.
// No dependencies.
package i2cm_pkg;

   // Operation / command codes
   localparam logic [2:0] OP_IDLE  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // Phase counter and the phases that close each operation
   localparam int unsigned PHASE_W   = 5;
   localparam int unsigned BIT_COUNT = 8;
   localparam logic [PHASE_W-1:0] PH_ZERO     = PHASE_W'(0);
   localparam logic [PHASE_W-1:0] PH_ONE      = PHASE_W'(1);
   localparam logic [PHASE_W-1:0] PH_TWO      = PHASE_W'(2);
   localparam logic [PHASE_W-1:0] PH_ACK      = PHASE_W'(2 * BIT_COUNT);
   localparam logic [PHASE_W-1:0] PH_ACK_HIGH = PHASE_W'(2 * BIT_COUNT + 1);

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       nack_seen;
      logic       refused;
   } rsp_type;

endpackage

### hw/rtl/i2cm_if.sv
// Valid/ready channels for the I2C master byte engine.
// Depends on i2cm_pkg for the request and response beat layouts.
interface i2cm_req_if;
   import i2cm_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface i2cm_rsp_if;
   import i2cm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/i2cm_phase_seq.sv
// Bus phase sequencer: operation state plus the SCL/SDA line registers.
// One phase per enabled cycle; depends on i2cm_pkg.
module i2cm_phase_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  i2cm_pkg::req_type item,
   output i2cm_pkg::rsp_type result
);
   import i2cm_pkg::*;

   logic [2:0]         operation_ff, operation_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [7:0]         shift_ff, shift_in;
   logic               ack_ff, ack_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;

   // Next state and result for one phase
   always_comb begin
      logic               is_cmd;
      logic [2:0]         op;
      logic [PHASE_W-1:0] ph;
      logic [7:0]         sh;
      logic               ack;
      logic               scl;
      logic               sda;
      logic               done;
      logic [7:0]         rx;
      logic               nack;
      logic               refused;

      is_cmd  = (item.kind >= OP_START) && (item.kind <= OP_READ);
      op      = operation_ff;
      ph      = phase_ff;
      sh      = shift_ff;
      ack     = ack_ff;
      scl     = scl_ff;
      sda     = sda_ff;
      done    = 1'b0;
      rx      = 8'h00;
      nack    = 1'b0;
      refused = 1'b0;

      // Command launch, or refusal while busy
      if (operation_ff == OP_IDLE) begin
         if (is_cmd) begin
            op = item.kind;
            ph = PH_ZERO;
            if (item.kind == OP_WRITE) begin
               sh = item.tx_byte;
            end else if (item.kind == OP_READ) begin
               sh  = 8'h00;
               ack = item.send_ack;
            end
         end
      end else if (is_cmd) begin
         refused = 1'b1;
      end

      // Line levels for this phase
      unique case (op)
         OP_START: begin
            if (ph == PH_ZERO) sda = 1'b1;
            else if (ph == PH_ONE) scl = 1'b1;
            else if (ph == PH_TWO) sda = 1'b0;
            else begin
               scl  = 1'b0;
               done = 1'b1;
            end
         end
         OP_STOP: begin
            if (ph == PH_ZERO) sda = 1'b0;
            else if (ph == PH_ONE) scl = 1'b1;
            else begin
               sda  = 1'b1;
               done = 1'b1;
            end
         end
         OP_WRITE: begin
            if (ph < PH_ACK) begin
               if (!ph[0]) begin
                  sda = sh[7];
                  scl = 1'b1;
               end else begin
                  scl = 1'b0;
                  sh  = {sh[6:0], 1'b0};
               end
            end else if (ph == PH_ACK) begin
               sda = 1'b1;
               scl = 1'b1;
            end else begin
               // slave ACK sampled from the level seen during the high phase
               scl  = 1'b0;
               nack = item.sda_in;
               done = 1'b1;
            end
         end
         OP_READ: begin
            if (ph < PH_ACK) begin
               if (!ph[0]) begin
                  sda = 1'b1;
                  scl = 1'b1;
               end else begin
                  scl = 1'b0;
                  sh  = {sh[6:0], item.sda_in};
               end
            end else if (ph == PH_ACK) begin
               sda = !ack;
            end else if (ph == PH_ACK_HIGH) begin
               scl = 1'b1;
            end else begin
               scl  = 1'b0;
               rx   = sh;
               done = 1'b1;
            end
         end
         default: begin
            op = OP_IDLE;
         end
      endcase

      // Phase advance / completion
      if (op != OP_IDLE) begin
         if (done) begin
            op = OP_IDLE;
            ph = PH_ZERO;
         end else begin
            ph = ph + PH_ONE;
         end
      end

      operation_in       = op;
      phase_in           = ph;
      shift_in           = sh;
      ack_in             = ack;
      scl_in             = scl;
      sda_in             = sda;
      result.scl_level   = scl;
      result.sda_release = sda;
      result.busy_res    = (op != OP_IDLE);
      result.done_res    = done;
      result.rx_byte     = rx;
      result.nack_seen   = nack;
      result.refused     = refused;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff <= OP_IDLE;
         phase_ff     <= PH_ZERO;
         shift_ff     <= 8'h00;
         ack_ff       <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
      end else if (step_en) begin
         operation_ff <= operation_in;
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         ack_ff       <= ack_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
      end
   end

endmodule

### hw/rtl/i2c_master_byte_engine_core.sv
// I2C master byte engine, top level: input register, phase sequencer, result register.
// Depends on i2cm_pkg, i2cm_if and i2cm_phase_seq.
// The input register holds a request beat; the sequencer steps and its response beat is
// registered when the result register is free or being emptied. Throughput: one beat per
// cycle while responses are taken; a request is taken while a response waits if it moves.
// Reset (synchronous): idle, SCL and SDA released, no beats held.
module i2c_master_byte_engine_core (
   input logic        clock,
   input logic        reset,
   i2cm_req_if.sink   req_if,
   i2cm_rsp_if.source rsp_if
);
   import i2cm_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type step_rsp;
   logic    advance;
   logic    take_req;

   // Sequencer steps when a held request can move into the result register
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign take_req = req_if.valid && req_if.ready;
   assign req_if.ready = !in_valid_ff || advance;

   assign in_valid_in  = take_req || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_if.ready);

   i2cm_phase_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .result  (step_rsp)
   );

   // Handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_data_ff <= req_if.payload;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

endmodule

### tb/sv/i2cm_phase_checker.sv
`timescale 1ns / 1ps
// Checker for the I2C master byte engine: watches the request and response channels,
// predicts each response beat from its own model of the bus phase sequencer and compares.
// Depends on i2cm_pkg and the channel interfaces in i2cm_if.
module i2cm_phase_checker (
   input  logic        clock,
   input  logic        reset,
   i2cm_req_if         req_mon,
   i2cm_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending,
   output int unsigned beats_checked,
   output int unsigned ops_done,
   output int unsigned refusals
);
   import i2cm_pkg::*;

   // Model state of the sequencer
   logic [2:0]         bus_op;
   logic [PHASE_W-1:0] phase_no;
   logic [7:0]         shift_reg;
   logic               ack_sel;
   logic               scl_line;
   logic               sda_line;

   rsp_type expected_phases[$];

   // One bus phase: update the model and return the response it gives
   function automatic rsp_type bus_phase_step(input req_type b);
      rsp_type            r;
      logic               is_cmd;
      logic               done_now;
      logic [PHASE_W-1:0] p;
      r        = '0;
      done_now = 1'b0;
      is_cmd   = (b.kind >= OP_START) && (b.kind <= OP_READ);

      // a command only starts from idle; otherwise it is refused and acts as a tick
      if (bus_op == OP_IDLE) begin
         if (is_cmd) begin
            bus_op   = b.kind;
            phase_no = PH_ZERO;
            if (b.kind == OP_WRITE) begin
               shift_reg = b.tx_byte;
            end else if (b.kind == OP_READ) begin
               shift_reg = '0;
               ack_sel   = b.send_ack;
            end
         end
      end else if (is_cmd) begin
         r.refused = 1'b1;
      end

      p = phase_no;
      case (bus_op)
         OP_START: begin
            if (p == PH_ZERO) sda_line = 1'b1;
            else if (p == PH_ONE) scl_line = 1'b1;
            else if (p == PH_TWO) sda_line = 1'b0;
            else begin
               scl_line = 1'b0;
               done_now = 1'b1;
            end
         end
         OP_STOP: begin
            if (p == PH_ZERO) sda_line = 1'b0;
            else if (p == PH_ONE) scl_line = 1'b1;
            else begin
               sda_line = 1'b1;
               done_now = 1'b1;
            end
         end
         OP_WRITE: begin
            if (p < PH_ACK) begin
               if (!p[0]) begin
                  sda_line = shift_reg[7];
                  scl_line = 1'b1;
               end else begin
                  scl_line  = 1'b0;
                  shift_reg = {shift_reg[6:0], 1'b0};
               end
            end else if (p == PH_ACK) begin
               sda_line = 1'b1;
               scl_line = 1'b1;
            end else begin
               // slave answer was on the line during the previous phase
               scl_line    = 1'b0;
               r.nack_seen = b.sda_in;
               done_now    = 1'b1;
            end
         end
         OP_READ: begin
            if (p < PH_ACK) begin
               if (!p[0]) begin
                  sda_line = 1'b1;
                  scl_line = 1'b1;
               end else begin
                  scl_line  = 1'b0;
                  shift_reg = {shift_reg[6:0], b.sda_in};
               end
            end else if (p == PH_ACK) begin
               sda_line = ~ack_sel;
            end else if (p == PH_ACK_HIGH) begin
               scl_line = 1'b1;
            end else begin
               scl_line  = 1'b0;
               r.rx_byte = shift_reg;
               done_now  = 1'b1;
            end
         end
         default: bus_op = OP_IDLE;
      endcase

      if (bus_op != OP_IDLE) begin
         if (done_now) begin
            bus_op   = OP_IDLE;
            phase_no = PH_ZERO;
         end else begin
            phase_no = phase_no + PH_ONE;
         end
      end

      r.scl_level   = scl_line;
      r.sda_release = sda_line;
      r.busy_res    = (bus_op != OP_IDLE);
      r.done_res    = done_now;
      return r;
   endfunction

   task automatic note_field(input string field, input int unsigned want,
                             input int unsigned got);
      if (want != got) begin
         fail_count++;
         $display("%0t: response beat %0d, %s expected 0x%0h actual 0x%0h",
                  $time, beats_checked, field, want, got);
      end
   endtask

   // Compare accepted response beats first, then queue the prediction for a new request
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         bus_op        = OP_IDLE;
         phase_no      = PH_ZERO;
         shift_reg     = '0;
         ack_sel       = 1'b0;
         scl_line      = 1'b1;
         sda_line      = 1'b1;
         expected_phases.delete();
         fail_count    = 0;
         beats_checked = 0;
         ops_done      = 0;
         refusals      = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_phases.size() == 0) begin
               fail_count++;
               $display("%0t: response beat with nothing expected, expected none, actual 0x%0h",
                        $time, rsp_mon.payload);
            end else begin
               want = expected_phases.pop_front();
               note_field("scl_level", want.scl_level, rsp_mon.payload.scl_level);
               note_field("sda_release", want.sda_release, rsp_mon.payload.sda_release);
               note_field("busy_res", want.busy_res, rsp_mon.payload.busy_res);
               note_field("done_res", want.done_res, rsp_mon.payload.done_res);
               note_field("rx_byte", want.rx_byte, rsp_mon.payload.rx_byte);
               note_field("nack_seen", want.nack_seen, rsp_mon.payload.nack_seen);
               note_field("refused", want.refused, rsp_mon.payload.refused);
               beats_checked++;
               if (want.done_res) ops_done++;
               if (want.refused) refusals++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_phases.push_back(bus_phase_step(req_mon.payload));
      end
      pending = expected_phases.size();
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the I2C master byte engine testbench: clock, reset, request and response beats.
// Drives start/stop/write/read phase sequences with noise, and gives the verdict.
// Depends on i2cm_pkg, i2cm_if, i2c_master_byte_engine_core and i2cm_phase_checker.
module tb_top;
   import i2cm_pkg::*;

   localparam int unsigned BEAT_TARGET  = 1600;
   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam int unsigned MAX_WAIT     = 4;
   localparam int unsigned END_DRAIN    = 8;
   localparam logic [2:0]  KIND_LAST    = 3'd7;
   localparam int          NO_INDEX     = -1;

   logic clock;
   logic reset;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned beats_checked;
   int unsigned ops_done;
   int unsigned refusals;
   int unsigned beats_sent;
   int unsigned cycles;
   logic        send_eager;
   logic        take_eager;

   i2cm_req_if req_if ();
   i2cm_rsp_if rsp_if ();

   i2c_master_byte_engine_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   i2cm_phase_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .fail_count    (fail_count),
      .pending       (pending),
      .beats_checked (beats_checked),
      .ops_done      (ops_done),
      .refusals      (refusals)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Random beat of the given kind
   function automatic req_type random_beat(input logic [2:0] kind);
      req_type b;
      b.kind     = kind;
      b.tx_byte  = 8'($urandom_range(255));
      b.send_ack = 1'($urandom_range(1));
      b.sda_in   = 1'($urandom_range(1));
      return b;
   endfunction

   // Hold off a random number of cycles, then present one beat until it is taken
   task automatic send_beat(input req_type b);
      int unsigned gap;
      gap = send_eager ? 0 : $urandom_range(MAX_WAIT);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   // Command beat followed by ticks for the rest of the operation.
   // noise_pct swaps ticks for stray kinds; refuse_at puts a command mid-operation;
   // last_sda, when not NO_INDEX, sets the line level seen on the closing phase.
   task automatic run_op(input logic [2:0] op, input logic [7:0] tx, input int noise_pct,
                         input int refuse_at, input int last_sda);
      int      n;
      req_type b;
      case (op)
         OP_START: n = 4;
         OP_STOP:  n = 3;
         OP_WRITE: n = 2 * BIT_COUNT + 2;
         default:  n = 2 * BIT_COUNT + 3;
      endcase
      for (int i = 0; i < n; i++) begin
         b = random_beat((i == 0) ? op : OP_IDLE);
         if (i == 0) b.tx_byte = tx;
         if (i > 0 && $urandom_range(99) < noise_pct)
            b.kind = 3'($urandom_range(OP_START, KIND_LAST));
         if (i == refuse_at) b.kind = 3'($urandom_range(OP_START, OP_READ));
         if (i == n - 1 && last_sda != NO_INDEX) b.sda_in = 1'(last_sda);
         send_beat(b);
      end
   endtask

   // Response side: random stall before each beat, with stretches of none
   initial begin
      rsp_if.ready = 1'b0;
      take_eager   = 1'b0;
      forever begin
         int unsigned stall;
         if ($urandom_range(63) == 0) take_eager = ~take_eager;
         stall = take_eager ? 0 : $urandom_range(MAX_WAIT);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Run limit
   initial begin
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_top: run limit of %0d cycles reached", LIMIT_CYCLES);
      $display("tb_top: errors");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      int unsigned pick;
      logic [7:0]  tx;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      beats_sent     = 0;
      send_eager     = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: spare kind while idle, start with a command refused mid-way,
      // write of all ones answered with NACK, stop
      send_beat(random_beat(KIND_LAST));
      run_op(OP_START, 8'h00, 0, 2, NO_INDEX);
      run_op(OP_WRITE, 8'hFF, 0, NO_INDEX, 1);
      run_op(OP_STOP, 8'h00, 0, NO_INDEX, NO_INDEX);

      // Random: mostly whole operations, some stray beats between them
      while (beats_sent < BEAT_TARGET) begin
         send_eager = ($urandom_range(9) == 0);
         pick = $urandom_range(99);
         case ($urandom_range(3))
            0:       tx = 8'h00;
            1:       tx = 8'hFF;
            default: tx = 8'($urandom_range(255));
         endcase
         if (pick < 8) begin
            repeat ($urandom_range(1, 3))
               send_beat(random_beat(3'($urandom_range(OP_IDLE, KIND_LAST))));
         end else if (pick < 25) begin
            run_op(OP_START, tx, 4, NO_INDEX, NO_INDEX);
         end else if (pick < 40) begin
            run_op(OP_STOP, tx, 4, NO_INDEX, NO_INDEX);
         end else if (pick < 70) begin
            run_op(OP_WRITE, tx, 4, NO_INDEX, NO_INDEX);
         end else begin
            run_op(OP_READ, tx, 4, NO_INDEX, NO_INDEX);
         end
      end
      req_if.valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (END_DRAIN) @(negedge clock);

      $display("tb_top: %0d request beats sent, %0d response beats compared",
               beats_sent, beats_checked);
      $display("tb_top: %0d bus operations finished, %0d commands turned away while busy",
               ops_done, refusals);
      if (fail_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

### i2c_master_byte_engine_core.f
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_if.sv
hw/rtl/i2cm_phase_seq.sv
hw/rtl/i2c_master_byte_engine_core.sv
tb/sv/i2cm_phase_checker.sv
tb/sv/tb_top.sv
